>>> sv/packbits_difference_decoder_unit_assert.svh
// Assertion macros for the decoder modules; pdd_back is the one that uses them.
// Depends on clk and arst_n being visible in the module that uses them.
`ifndef PACKBITS_DIFFERENCE_DECODER_UNIT_ASSERT_SVH
`define PACKBITS_DIFFERENCE_DECODER_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define PDD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pdd_pkg.sv
// Package for the run and difference decoder: payload types and header constants.
// Used by every module of the decoder; depends on nothing.
package pdd_pkg;

	localparam logic [7:0] LIT_HDR_LIMIT = 8'd33;
	localparam logic [7:0] REP_HDR_LIMIT = 8'd128;
	localparam logic [7:0] DIFF_BIAS     = 8'd32;
	localparam logic [7:0] REP_BIAS      = 8'd127;
	localparam logic [1:0] CODE_NEG_ONE  = 2'h3;
	localparam int         LANES         = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_stream;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel0;
		logic [7:0] pixel1;
		logic [7:0] pixel2;
		logic [7:0] pixel3;
		logic [2:0] pixel_count;
		logic       last_of_run;
	} out_t;

	typedef struct packed {
		logic [LANES-1:0][7:0] pix;
		logic [7:0]            total;
	} cmd_t;

endpackage

>>> sv/pdd_front.sv
// Front end of the decoder: parses headers and turns each data byte into a command.
// Depends on pdd_pkg.
module pdd_front import pdd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	input  logic q_full,
	output logic full,
	output logic cmd_v,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_DIFF,
		PH_REPEAT
	} phase_t;

	phase_t     phase_q, ph, nx_phase;
	logic [6:0] items_q, il, nx_items;
	logic [7:0] prior_q, pr, nx_prior;
	logic [7:0] rep_q, rl, nx_rep;
	logic       acc;
	logic [7:0] b;
	logic [2:0] nd;
	logic [LANES-1:0][7:0] dpx;
	logic [7:0] acc_px;
	logic [1:0] code;

	assign full = q_full;
	assign acc  = push && !q_full;
	assign b    = item.in_byte;
	assign ph   = item.start_of_stream ? PH_HEADER : phase_q;
	assign il   = item.start_of_stream ? 7'd0 : items_q;
	assign pr   = item.start_of_stream ? 8'd0 : prior_q;
	assign rl   = item.start_of_stream ? 8'd0 : rep_q;

	always_comb begin
		nd = (il >= 7'd4) ? 3'd4 : il[2:0];
		if (nd == 3'd0) begin
			nd = 3'd1;
		end
		acc_px = pr;
		code   = 2'd0;
		for (int j = 0; j < LANES; j++) begin
			code   = b[2*j +: 2];
			acc_px = acc_px + ((code == CODE_NEG_ONE) ? 8'hFF : {6'd0, code});
			dpx[j] = acc_px;
		end
	end

	always_comb begin
		nx_phase  = ph;
		nx_items  = il;
		nx_prior  = pr;
		nx_rep    = rl;
		cmd.pix   = {LANES{b}};
		cmd.total = 8'd1;
		cmd_v     = acc && (ph != PH_HEADER);
		unique case (ph)
			PH_HEADER: begin
				if (b < LIT_HDR_LIMIT) begin
					nx_items = b[6:0] + 7'd1;
					nx_phase = PH_LITERAL;
				end else if (b < REP_HDR_LIMIT) begin
					nx_items = 7'(b - DIFF_BIAS);
					nx_phase = PH_DIFF;
				end else begin
					nx_rep   = b - REP_BIAS;
					nx_phase = PH_REPEAT;
				end
			end
			PH_LITERAL: begin
				nx_prior = b;
				nx_items = (il != 7'd0) ? il - 7'd1 : il;
				if (nx_items == 7'd0) begin
					nx_phase = PH_HEADER;
				end
			end
			PH_DIFF: begin
				cmd.pix   = dpx;
				cmd.total = {5'd0, nd};
				nx_prior  = dpx[nd[1:0] - 2'd1];
				nx_items  = (il > {4'd0, nd}) ? il - {4'd0, nd} : 7'd0;
				if (nx_items == 7'd0) begin
					nx_phase = PH_HEADER;
				end
			end
			PH_REPEAT: begin
				cmd.total = (rl == 8'd0) ? 8'd1 : rl;
				nx_prior  = b;
				nx_rep    = 8'd0;
				nx_phase  = PH_HEADER;
			end
			default: begin
				nx_phase = PH_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			items_q <= 7'd0;
			prior_q <= 8'd0;
			rep_q   <= 8'd0;
		end else if (acc) begin
			phase_q <= nx_phase;
			items_q <= nx_items;
			prior_q <= nx_prior;
			rep_q   <= nx_rep;
		end
	end

endmodule

>>> sv/pdd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on pdd_pkg for the command type.
module pdd_fifo import pdd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr, rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr      = wr_en && !full;
	assign rd      = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

>>> sv/pdd_back.sv
// Back end of the decoder: splits each command into results of up to four pixels.
// Depends on pdd_pkg and the assertion macros.
`include "packbits_difference_decoder_unit_assert.svh"

module pdd_back import pdd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_v,
	input  cmd_t head,
	output logic head_rd,
	input  logic pop,
	output logic empty,
	output out_t result
);

	logic       out_v_q;
	out_t       out_q;
	logic [7:0] sent_q;
	logic [7:0] rem;
	logic [2:0] n;
	logic       last;
	logic       adv;
	out_t       nx_out;

	assign rem     = head.total - sent_q;
	assign n       = (rem >= 8'd4) ? 3'd4 : rem[2:0];
	assign last    = (rem <= 8'd4);
	assign adv     = head_v && (!out_v_q || pop);
	assign head_rd = adv && last;
	assign empty   = !out_v_q;
	assign result  = out_q;

	always_comb begin
		nx_out.pixel0      = head.pix[0];
		nx_out.pixel1      = (n >= 3'd2) ? head.pix[1] : 8'd0;
		nx_out.pixel2      = (n >= 3'd3) ? head.pix[2] : 8'd0;
		nx_out.pixel3      = (n == 3'd4) ? head.pix[3] : 8'd0;
		nx_out.pixel_count = n;
		nx_out.last_of_run = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sent_q  <= 8'd0;
		end else if (adv) begin
			out_v_q <= 1'b1;
			sent_q  <= last ? 8'd0 : sent_q + 8'd4;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= nx_out;
		end
	end

	`PDD_ASSERT_NOW(a_count_range, out_v_q, (out_q.pixel_count != 3'd0) && (out_q.pixel_count <= 3'd4), "pixel count out of range")
	`PDD_ASSERT_NOW(a_full_unless_last, out_v_q && !out_q.last_of_run, out_q.pixel_count == 3'd4, "short result before end of run")
	`PDD_ASSERT_NOW(a_unused_zero, out_v_q && (out_q.pixel_count != 3'd4), out_q.pixel3 == 8'd0, "unused pixel slot not zero")
	`PDD_ASSERT_NEXT(a_split_progress, adv && !last, sent_q != 8'd0, "split command lost its progress")

endmodule

>>> sv/packbits_difference_decoder_unit.sv
// Run and difference decoder: compressed bytes in, up to four pixels a result out.
// Data path: a data byte's command enters the queue, and the back end then registers its results.
// Throughput: one byte per cycle while full is low; a repeat of length L gives ceil(L/4) results,
// and the command queue of QDEPTH entries lets the input run on meanwhile.
// Reset: arst_n clears parser state and prior pixel, empties the queue and the output.
// Depends on pdd_pkg, pdd_front, pdd_fifo and pdd_back.
module packbits_difference_decoder_unit import pdd_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	logic cmd_v, q_full, q_empty, head_rd;
	cmd_t cmd, head;

	pdd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.full   (full),
		.cmd_v  (cmd_v),
		.cmd    (cmd)
	);

	pdd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_v),
		.wr_data (cmd),
		.rd_en   (head_rd),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	pdd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_v  (!q_empty),
		.head    (head),
		.head_rd (head_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
